>>> rtl/skh32_pkg.sv
// shared types, constants and mixing functions for the short-key hash
package skh32_pkg;

  localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_M1  = 32'h85ebca6b;
  localparam logic [31:0] MIX_M2  = 32'hc2b2ae35;
  localparam logic [31:0] MUR_ADD = 32'he6546b64;

  localparam int unsigned ROT_X   = 17;
  localparam int unsigned ROT_ACC = 19;
  localparam int unsigned SEED_C  = 9;

  localparam logic [3:0] LEN_MIN = 4'd5;
  localparam logic [3:0] LEN_MAX = 4'd12;

  // edges from accepting an item to its result being shown on out_valid
  localparam int unsigned PIPE_LATENCY = 9;

  typedef struct packed {
    logic valid;
    logic err;
  } ctl_t;

  function automatic logic [31:0] rotr32(input logic [31:0] v, input int unsigned s);
    rotr32 = (v >> s) | (v << (32 - s));
  endfunction

  // accumulator half of the murmur combine step
  function automatic logic [31:0] mur_acc(input logic [31:0] acc, input logic [31:0] y);
    logic [31:0] r;
    r = rotr32(acc ^ y, ROT_ACC);
    mur_acc = (r << 2) + r + MUR_ADD;
  endfunction

endpackage

>>> rtl/short_key_hash32.sv
// Short-key 32-bit hash (5 to 12 byte keys). One item is taken in every cycle:
// busy never rises, and each result appears on out_valid once it has passed
// through the pipeline (input register, five mix stages that pre-scramble and
// combine, two finalizer multiply stages, result register). The receiver cannot
// stall and need not: every item gives exactly one result, in order. A length
// outside 5 to 12 gives out_length_error high with out_hash_value 0.
module short_key_hash32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_key_low,
  input  logic [31:0] in_key_high,
  input  logic [3:0]  in_key_length,
  output logic        out_valid,
  output logic [31:0] out_hash_value,
  output logic        out_length_error
);

  skh32_pkg::ctl_t load_ctl, mix_ctl;
  logic [31:0]     a, b, c, d, h;

  // fully pipelined, nothing ever holds the input off
  assign busy = 1'b0;

  skh32_load u_load (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (start && !busy),
    .key_low    (in_key_low),
    .key_high   (in_key_high),
    .key_length (in_key_length),
    .ctl        (load_ctl),
    .a          (a),
    .b          (b),
    .c          (c),
    .d          (d)
  );

  skh32_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (load_ctl),
    .a       (a),
    .b       (b),
    .c       (c),
    .d       (d),
    .out_ctl (mix_ctl),
    .h       (h)
  );

  skh32_fmix u_fmix (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ctl           (mix_ctl),
    .h                (h),
    .out_valid        (out_valid),
    .out_hash_value   (out_hash_value),
    .out_length_error (out_length_error)
  );

endmodule

>>> rtl/skh32_load.sv
// input register stage: length check, word selection and seed add
module skh32_load (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [63:0]         key_low,
  input  logic [31:0]         key_high,
  input  logic [3:0]          key_length,
  output skh32_pkg::ctl_t     ctl,
  output logic [31:0]         a,
  output logic [31:0]         b,
  output logic [31:0]         c,
  output logic [31:0]         d
);

  logic [95:0]     key;
  logic            err;
  logic [3:0]      off_b;
  logic [3:0]      off_c;
  logic [6:0]      len5;
  skh32_pkg::ctl_t ctl_nxt, ctl_r;
  logic [31:0]     a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0]     a_r, b_r, c_r, d_r;

  assign key = {key_high, key_low};

  always_comb begin
    err = !(key_length inside {[skh32_pkg::LEN_MIN:skh32_pkg::LEN_MAX]});
    // keep the part-select in range on a bad length, result is zeroed later
    off_b = err ? 4'd0 : 4'(key_length - 4'd4);
    off_c = key_length[3] ? 4'd4 : 4'd0;
    len5  = 7'({3'b000, key_length} << 2) + 7'(key_length);
    a_nxt = 32'(key_length) + key[0 +: 32];
    b_nxt = 32'(len5) + key[{off_b, 3'b000} +: 32];
    c_nxt = 32'(skh32_pkg::SEED_C) + key[{off_c, 3'b000} +: 32];
    d_nxt = 32'(len5);
    ctl_nxt.valid = take;
    ctl_nxt.err   = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  assign ctl = ctl_r;
  assign a   = a_r;
  assign b   = b_r;
  assign c   = c_r;
  assign d   = d_r;

endmodule

>>> rtl/skh32_mix.sv
// pre-scramble multiplies, then three chained murmur combine steps (shift and add)
module skh32_mix (
  input  logic            clk,
  input  logic            rst_n,
  input  skh32_pkg::ctl_t in_ctl,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  input  logic [31:0]     c,
  input  logic [31:0]     d,
  output skh32_pkg::ctl_t out_ctl,
  output logic [31:0]     h
);

  skh32_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [31:0] xa_nxt, xb_nxt, xc_nxt, xa_r, xb_r, xc_r, d1_r;
  logic [31:0] ya_nxt, yb_nxt, yc_nxt, ya_r, yb_r, yc_r, d2_r;
  logic [31:0] h1_nxt, h1_r, yb3_r, yc3_r;
  logic [31:0] h2_nxt, h2_r, yc4_r;
  logic [31:0] h3_nxt, h3_r;

  // the three key words are pre-scrambled side by side, then folded in one by one
  always_comb begin
    xa_nxt = a * skh32_pkg::MUR_C1;
    xb_nxt = b * skh32_pkg::MUR_C1;
    xc_nxt = c * skh32_pkg::MUR_C1;
    ya_nxt = skh32_pkg::rotr32(xa_r, skh32_pkg::ROT_X) * skh32_pkg::MUR_C2;
    yb_nxt = skh32_pkg::rotr32(xb_r, skh32_pkg::ROT_X) * skh32_pkg::MUR_C2;
    yc_nxt = skh32_pkg::rotr32(xc_r, skh32_pkg::ROT_X) * skh32_pkg::MUR_C2;
    h1_nxt = skh32_pkg::mur_acc(d2_r, ya_r);
    h2_nxt = skh32_pkg::mur_acc(h1_r, yb3_r);
    h3_nxt = skh32_pkg::mur_acc(h2_r, yc4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    xa_r  <= xa_nxt;
    xb_r  <= xb_nxt;
    xc_r  <= xc_nxt;
    d1_r  <= d;
    ya_r  <= ya_nxt;
    yb_r  <= yb_nxt;
    yc_r  <= yc_nxt;
    d2_r  <= d1_r;
    h1_r  <= h1_nxt;
    yb3_r <= yb_r;
    yc3_r <= yc_r;
    h2_r  <= h2_nxt;
    yc4_r <= yc3_r;
    h3_r  <= h3_nxt;
  end

  assign out_ctl = ctl5_r;
  assign h       = h3_r;

endmodule

>>> rtl/skh32_fmix.sv
// murmur finalizer over two multiply stages, then the result register (zero on a length error)
module skh32_fmix (
  input  logic            clk,
  input  logic            rst_n,
  input  skh32_pkg::ctl_t in_ctl,
  input  logic [31:0]     h,
  output logic            out_valid,
  output logic [31:0]     out_hash_value,
  output logic            out_length_error
);

  skh32_pkg::ctl_t ctl1_r, ctl2_r;
  logic [31:0] f1_nxt, f1_r, f2_nxt, f2_r;
  logic        valid_r, err_r;
  logic [31:0] hash_nxt, hash_r;

  always_comb begin
    f1_nxt   = (h ^ (h >> 16)) * skh32_pkg::MIX_M1;
    f2_nxt   = (f1_r ^ (f1_r >> 13)) * skh32_pkg::MIX_M2;
    hash_nxt = ctl2_r.err ? 32'd0 : (f2_r ^ (f2_r >> 16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      ctl1_r  <= in_ctl;
      ctl2_r  <= ctl1_r;
      valid_r <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_r   <= f1_nxt;
    f2_r   <= f2_nxt;
    hash_r <= hash_nxt;
    err_r  <= ctl2_r.err;
  end

  assign out_valid        = valid_r;
  assign out_hash_value   = hash_r;
  assign out_length_error = err_r;

endmodule

>>> rtl/skh32_checker.sv
// port-level checks for the short-key hash, bound to the top level
module skh32_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [3:0]  in_key_length,
  input logic        out_valid,
  input logic [31:0] out_hash_value,
  input logic        out_length_error
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // one result per accepted item, at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy && rst_n, skh32_pkg::PIPE_LATENCY))
    else $error("result strobe does not match accepted item");

  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length_error ==
      $past(in_key_length < 4'd5 || in_key_length > 4'd12, skh32_pkg::PIPE_LATENCY))
    else $error("length error flag does not follow item length");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> out_hash_value == 32'd0)
    else $error("hash not zero on length error");

endmodule

bind short_key_hash32 skh32_checker u_skh32_checker (.*);
